// ===== sv/csa_pkg.sv =====
// Shared constants, codes and types of the contact-score alignment block.
package csa_pkg;

  // Chain capacities
  localparam int MaxFirst  = 64;
  localparam int MaxSecond = 64;

  localparam int IdxW1 = $clog2(MaxFirst);
  localparam int IdxW2 = $clog2(MaxSecond);
  localparam int CntW1 = $clog2(MaxFirst + 1);
  localparam int CntW2 = $clog2(MaxSecond + 1);

  // Field widths
  localparam int CoordW    = 16;
  localparam int AtomW     = 3 * CoordW;
  localparam int CmdW      = 2;
  localparam int CountW    = 7;
  localparam int LimitW    = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  localparam int FieldIdxW = 6;

  // Arithmetic widths
  localparam int ScoreW     = 32;
  localparam int ProdW      = 35;
  localparam int MulAW      = 25;
  localparam int MulBW      = 18;
  localparam int ScoreScale = 1000;
  localparam int RoundHalf  = 32768;
  localparam int FracBits   = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_RUN         = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_COUNT  = 2'd0,
    REG_SECOND_COUNT = 2'd1,
    REG_LIMIT        = 2'd2
  } reg_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

endpackage

// ===== sv/csa_if.sv =====
// Handshake channels of the contact-score alignment block.
interface csa_in_if;
  logic                              valid;
  logic                              ready;
  logic [csa_pkg::CmdW-1:0]          command;
  logic signed [csa_pkg::CoordW-1:0] coord_x;
  logic signed [csa_pkg::CoordW-1:0] coord_y;
  logic signed [csa_pkg::CoordW-1:0] coord_z;
  modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface csa_out_if;
  logic                              valid;
  logic                              ready;
  logic [csa_pkg::FieldIdxW-1:0]     first_index;
  logic [csa_pkg::FieldIdxW-1:0]     partner_index;
  logic                              matched;
  logic                              last;
  modport source (output valid, first_index, partner_index, matched, last, input ready);
  modport sink (input valid, first_index, partner_index, matched, last, output ready);
endinterface

interface csa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csa_pkg::CfgIdxW-1:0]     reg_index;
  logic [csa_pkg::CfgDataW-1:0]    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/csa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/csa_mul.sv =====
// Shared signed multiplier with registered product.
module csa_mul (
  input  logic                       clk_i,
  input  csa_pkg::mul_req_t          req_i,
  output logic [csa_pkg::ProdW-1:0]  prod_o
);

  logic signed [csa_pkg::MulAW+csa_pkg::MulBW-1:0] product;

  assign product = req_i.a * req_i.b;

  // Register the product for the next step
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= product[csa_pkg::ProdW-1:0];
    end
  end

endmodule

// ===== sv/contact_score_alignment_dp.sv =====
// Top level: sequencer, coordinate stores, score table and backtrace.
//
// Loads (command 0 and 1) write the next free slot of a chain; a load beyond
// the capacity is dropped. A run (command 2) holds the input channel busy
// until its last result item is taken. It clears the partner store, then
// walks every cell of the n1 x n2 table in row order through one shared
// multiplier, each cell in the steps read, three squares, accumulate, limit
// compare and scale, and update, with a fetch of the first-chain atom at the
// start of each row. The backtrace then reads the table through one
// registered port, and each result item is held until it is taken before
// the next one is read. Counts of 0 act as 1 and counts above the capacity
// act as the capacity; load positions restart at zero after a run.
module contact_score_alignment_dp (
  input  logic         clk_i,
  input  logic         rst_ni,
  csa_in_if.sink       in_ch,
  csa_out_if.source    out_ch,
  csa_cfg_if.sink      cfg_ch
);

  localparam int TabAW = csa_pkg::IdxW1 + csa_pkg::IdxW2;
  localparam int TabW  = csa_pkg::ScoreW + csa_pkg::IdxW2;
  localparam int PartW = csa_pkg::IdxW2 + 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_ROW_RD, ST_ROW_WT, ST_CELL_RD, ST_SQ0, ST_SQ1, ST_SQ2,
    ST_SQ3, ST_LIM, ST_UPD, ST_BT_CHK, ST_BT_DW, ST_BT_SCHK, ST_BT_SW,
    ST_BT_FIX, ST_BT_FW, ST_OUT_RD, ST_OUT_WT, ST_OUT_SHOW
  } state_e;

  state_e state_q;

  logic [csa_pkg::CountW-1:0]  first_count_q, second_count_q;
  logic [csa_pkg::LimitW-1:0]  limit_q;
  logic [csa_pkg::CntW1-1:0]   pos1_q, n1_q, n1_c;
  logic [csa_pkg::CntW2-1:0]   pos2_q, n2_q, n2_c;
  logic [csa_pkg::IdxW1-1:0]   i_q;
  logic [csa_pkg::IdxW2-1:0]   j_q;
  logic [csa_pkg::IdxW1:0]     r1_q, r1_inc;
  logic [csa_pkg::IdxW2:0]     r2_q;
  logic signed [csa_pkg::CoordW-1:0] fx_q, fy_q, fz_q;
  logic [csa_pkg::ProdW-1:0]   acc_q, prod;
  logic                        hit_q;
  logic [csa_pkg::ScoreW-1:0]  up_q, prm_q, best_q, dval_q;
  logic [csa_pkg::IdxW2-1:0]   mk_q;

  logic [csa_pkg::FieldIdxW-1:0] out_first_q, out_partner_q;
  logic                          out_matched_q, out_last_q, out_valid_q;

  logic in_acc, load1, load2;
  csa_pkg::mul_req_t mul_req;

  logic [csa_pkg::AtomW-1:0] first_rd, second_rd, in_atom;
  logic [csa_pkg::ScoreW-1:0] row_rd, pair, diag, val, best_n;
  logic [csa_pkg::IdxW2-1:0]  mk_n;
  logic [TabW-1:0]            tab_rd;
  logic [TabAW-1:0]           tab_raddr;
  logic                       tab_re;
  logic [PartW-1:0]           part_rd, part_wdata;
  logic                       part_we;
  logic signed [csa_pkg::CoordW:0] dsel;
  logic signed [csa_pkg::CoordW-1:0] fsel, ssel;
  logic [csa_pkg::LimitW-1:0] lim_diff;
  logic                       r1_neg, r2_neg;

  // Handshake
  assign in_ch.ready  = (state_q == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign load1  = in_acc && (in_ch.command == csa_pkg::CMD_LOAD_FIRST)
                  && (int'(pos1_q) < csa_pkg::MaxFirst);
  assign load2  = in_acc && (in_ch.command == csa_pkg::CMD_LOAD_SECOND)
                  && (int'(pos2_q) < csa_pkg::MaxSecond);
  assign in_atom = {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};

  assign out_ch.valid         = out_valid_q;
  assign out_ch.first_index   = out_first_q;
  assign out_ch.partner_index = out_partner_q;
  assign out_ch.matched       = out_matched_q;
  assign out_ch.last          = out_last_q;

  // Clamp counts into range
  always_comb begin
    if (first_count_q == '0) begin
      n1_c = csa_pkg::CntW1'(1);
    end else if (int'(first_count_q) > csa_pkg::MaxFirst) begin
      n1_c = csa_pkg::CntW1'(csa_pkg::MaxFirst);
    end else begin
      n1_c = csa_pkg::CntW1'(first_count_q);
    end
    if (second_count_q == '0) begin
      n2_c = csa_pkg::CntW2'(1);
    end else if (int'(second_count_q) > csa_pkg::MaxSecond) begin
      n2_c = csa_pkg::CntW2'(csa_pkg::MaxSecond);
    end else begin
      n2_c = csa_pkg::CntW2'(second_count_q);
    end
  end

  // Coordinate stores
  csa_ram #(.Width(csa_pkg::AtomW), .Depth(csa_pkg::MaxFirst)) u_first (
    .clk_i, .we_i(load1), .waddr_i(pos1_q[csa_pkg::IdxW1-1:0]), .wdata_i(in_atom),
    .re_i(state_q == ST_ROW_RD), .raddr_i(i_q), .rdata_o(first_rd)
  );
  csa_ram #(.Width(csa_pkg::AtomW), .Depth(csa_pkg::MaxSecond)) u_second (
    .clk_i, .we_i(load2), .waddr_i(pos2_q[csa_pkg::IdxW2-1:0]), .wdata_i(in_atom),
    .re_i(state_q == ST_CELL_RD), .raddr_i(j_q), .rdata_o(second_rd)
  );

  // Previous-row score buffer
  csa_ram #(.Width(csa_pkg::ScoreW), .Depth(csa_pkg::MaxSecond)) u_row (
    .clk_i, .we_i(state_q == ST_UPD), .waddr_i(j_q), .wdata_i(val),
    .re_i(state_q == ST_CELL_RD), .raddr_i(j_q), .rdata_o(row_rd)
  );

  // Table of row running maximum and its first column
  assign r1_inc = r1_q + 1'b1;
  assign r1_neg = r1_q[csa_pkg::IdxW1];
  assign r2_neg = r2_q[csa_pkg::IdxW2];
  assign tab_re = (state_q == ST_BT_CHK && !r1_neg && !r2_neg)
               || (state_q == ST_BT_SCHK && !r1_neg) || (state_q == ST_BT_FIX);
  assign tab_raddr = (state_q == ST_BT_FIX)
                   ? {r1_inc[csa_pkg::IdxW1-1:0], r2_q[csa_pkg::IdxW2-1:0]}
                   : {r1_q[csa_pkg::IdxW1-1:0], r2_q[csa_pkg::IdxW2-1:0]};
  csa_ram #(.Width(TabW), .Depth(2 ** TabAW)) u_tab (
    .clk_i, .we_i(state_q == ST_UPD), .waddr_i({i_q, j_q}), .wdata_i({best_n, mk_n}),
    .re_i(tab_re), .raddr_i(tab_raddr), .rdata_o(tab_rd)
  );

  // Partner store: cleared at run start, filled by the backtrace
  assign part_we    = (state_q == ST_CLR) || (state_q == ST_BT_FW);
  assign part_wdata = (state_q == ST_BT_FW) ? {1'b1, tab_rd[csa_pkg::IdxW2-1:0]} : '0;
  csa_ram #(.Width(PartW), .Depth(csa_pkg::MaxFirst)) u_part (
    .clk_i, .we_i(part_we),
    .waddr_i((state_q == ST_BT_FW) ? r1_q[csa_pkg::IdxW1-1:0] : i_q),
    .wdata_i(part_wdata), .re_i(state_q == ST_OUT_RD), .raddr_i(i_q), .rdata_o(part_rd)
  );

  // Select the coordinate pair and feed the shared multiplier
  assign lim_diff = limit_q - acc_q[csa_pkg::LimitW-1:0];
  always_comb begin
    unique case (state_q)
      ST_SQ0: begin
        fsel = fx_q;
        ssel = second_rd[3*csa_pkg::CoordW-1:2*csa_pkg::CoordW];
      end
      ST_SQ1: begin
        fsel = fy_q;
        ssel = second_rd[2*csa_pkg::CoordW-1:csa_pkg::CoordW];
      end
      default: begin
        fsel = fz_q;
        ssel = second_rd[csa_pkg::CoordW-1:0];
      end
    endcase
    dsel = {fsel[csa_pkg::CoordW-1], fsel} - {ssel[csa_pkg::CoordW-1], ssel};
    if (state_q == ST_LIM) begin
      mul_req.en = (acc_q < csa_pkg::ProdW'(limit_q));
      mul_req.a  = csa_pkg::MulAW'($signed({1'b0, lim_diff}));
      mul_req.b  = csa_pkg::MulBW'(csa_pkg::ScoreScale);
    end else begin
      mul_req.en = (state_q == ST_SQ0) || (state_q == ST_SQ1) || (state_q == ST_SQ2);
      mul_req.a  = csa_pkg::MulAW'(dsel);
      mul_req.b  = csa_pkg::MulBW'(dsel);
    end
  end

  csa_mul u_mul (.clk_i, .req_i(mul_req), .prod_o(prod));

  // Cell update: rounded pair score, best of up and diagonal, row running max
  always_comb begin
    logic [csa_pkg::ProdW-1:0] rnd;
    rnd  = prod + csa_pkg::ProdW'(csa_pkg::RoundHalf);
    pair = hit_q ? csa_pkg::ScoreW'(rnd[csa_pkg::ProdW-1:csa_pkg::FracBits]) : '0;
    diag = prm_q + pair;
    if (i_q == '0) begin
      val = pair;
    end else if (j_q == '0) begin
      val = (up_q > pair) ? up_q : pair;
    end else begin
      val = (up_q > diag) ? up_q : diag;
    end
    if (j_q == '0) begin
      best_n = val;
      mk_n   = '0;
    end else if (val > best_q) begin
      best_n = val;
      mk_n   = j_q;
    end else begin
      best_n = best_q;
      mk_n   = mk_q;
    end
  end

  // Sequencer, registers and result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      first_count_q  <= csa_pkg::CountW'(64);
      second_count_q <= csa_pkg::CountW'(64);
      limit_q        <= csa_pkg::LimitW'(1048576);
      pos1_q         <= '0;
      pos2_q         <= '0;
      n1_q           <= '0;
      n2_q           <= '0;
      i_q            <= '0;
      j_q            <= '0;
      r1_q           <= '0;
      r2_q           <= '0;
      fx_q           <= '0;
      fy_q           <= '0;
      fz_q           <= '0;
      acc_q          <= '0;
      hit_q          <= 1'b0;
      up_q           <= '0;
      prm_q          <= '0;
      best_q         <= '0;
      mk_q           <= '0;
      dval_q         <= '0;
      out_valid_q    <= 1'b0;
      out_first_q    <= '0;
      out_partner_q  <= '0;
      out_matched_q  <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.reg_index)
          csa_pkg::REG_FIRST_COUNT:  first_count_q  <= cfg_ch.wdata[csa_pkg::CountW-1:0];
          csa_pkg::REG_SECOND_COUNT: second_count_q <= cfg_ch.wdata[csa_pkg::CountW-1:0];
          csa_pkg::REG_LIMIT:        limit_q        <= cfg_ch.wdata[csa_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (load1) begin
            pos1_q <= pos1_q + 1'b1;
          end
          if (load2) begin
            pos2_q <= pos2_q + 1'b1;
          end
          if (in_acc && in_ch.command == csa_pkg::CMD_RUN) begin
            n1_q    <= n1_c;
            n2_q    <= n2_c;
            i_q     <= '0;
            state_q <= ST_CLR;
          end
        end
        ST_CLR: begin
          if (csa_pkg::CntW1'(i_q) == n1_q - 1'b1) begin
            i_q     <= '0;
            state_q <= ST_ROW_RD;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_ROW_RD: state_q <= ST_ROW_WT;
        ST_ROW_WT: begin
          fx_q    <= first_rd[3*csa_pkg::CoordW-1:2*csa_pkg::CoordW];
          fy_q    <= first_rd[2*csa_pkg::CoordW-1:csa_pkg::CoordW];
          fz_q    <= first_rd[csa_pkg::CoordW-1:0];
          j_q     <= '0;
          prm_q   <= '0;
          state_q <= ST_CELL_RD;
        end
        ST_CELL_RD: state_q <= ST_SQ0;
        ST_SQ0: begin
          up_q    <= row_rd;
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          acc_q   <= prod;
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          acc_q   <= acc_q + prod;
          state_q <= ST_SQ3;
        end
        ST_SQ3: begin
          acc_q   <= acc_q + prod;
          state_q <= ST_LIM;
        end
        ST_LIM: begin
          hit_q   <= (acc_q < csa_pkg::ProdW'(limit_q));
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          best_q <= best_n;
          mk_q   <= mk_n;
          prm_q  <= (up_q > prm_q) ? up_q : prm_q;
          if (csa_pkg::CntW2'(j_q) == n2_q - 1'b1) begin
            if (csa_pkg::CntW1'(i_q) == n1_q - 1'b1) begin
              r1_q    <= (csa_pkg::IdxW1 + 1)'(n1_q - 1'b1);
              r2_q    <= (csa_pkg::IdxW2 + 1)'(n2_q - 1'b1);
              state_q <= ST_BT_CHK;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_ROW_RD;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_CELL_RD;
          end
        end
        ST_BT_CHK: begin
          if (r1_neg || r2_neg) begin
            i_q     <= '0;
            state_q <= ST_OUT_RD;
          end else begin
            state_q <= ST_BT_DW;
          end
        end
        ST_BT_DW: begin
          dval_q <= tab_rd[TabW-1:csa_pkg::IdxW2];
          if (tab_rd[TabW-1:csa_pkg::IdxW2] == '0) begin
            i_q     <= '0;
            state_q <= ST_OUT_RD;
          end else begin
            state_q <= ST_BT_SCHK;
          end
        end
        ST_BT_SCHK: state_q <= r1_neg ? ST_BT_FIX : ST_BT_SW;
        ST_BT_SW: begin
          if (tab_rd[TabW-1:csa_pkg::IdxW2] < dval_q) begin
            state_q <= ST_BT_FIX;
          end else begin
            r1_q    <= r1_q - 1'b1;
            state_q <= ST_BT_SCHK;
          end
        end
        ST_BT_FIX: begin
          r1_q    <= r1_inc;
          state_q <= ST_BT_FW;
        end
        ST_BT_FW: begin
          r2_q    <= {1'b0, tab_rd[csa_pkg::IdxW2-1:0]} - 1'b1;
          r1_q    <= r1_q - 1'b1;
          state_q <= ST_BT_CHK;
        end
        ST_OUT_RD: state_q <= ST_OUT_WT;
        ST_OUT_WT: begin
          out_first_q   <= csa_pkg::FieldIdxW'(i_q);
          out_partner_q <= part_rd[PartW-1] ?
                           csa_pkg::FieldIdxW'(part_rd[csa_pkg::IdxW2-1:0]) : '0;
          out_matched_q <= part_rd[PartW-1];
          out_last_q    <= (csa_pkg::CntW1'(i_q) == n1_q - 1'b1);
          out_valid_q   <= 1'b1;
          state_q       <= ST_OUT_SHOW;
        end
        ST_OUT_SHOW: begin
          if (out_ch.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              pos1_q  <= '0;
              pos2_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
